@@ sv/hpid_pkg.sv @@
package hpid_pkg;

  localparam int FULL_TURN = 368640;
  localparam int HALF_TURN = 184320;
  localparam int DRIVE_MAX = 12000;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_GAIN_P          = 3'd0;
  localparam reg_idx_t REG_GAIN_I          = 3'd1;
  localparam reg_idx_t REG_GAIN_D          = 3'd2;
  localparam reg_idx_t REG_INTEGRAL_WINDOW = 3'd3;
  localparam reg_idx_t REG_INTEGRAL_CLEAR  = 3'd4;
  localparam reg_idx_t REG_STALL_BAND      = 3'd5;
  localparam reg_idx_t REG_SETTLE_BAND     = 3'd6;

  localparam logic [15:0] GAIN_P_RST          = 16'd25600;
  localparam logic [15:0] GAIN_I_RST          = 16'd1024;
  localparam logic [15:0] GAIN_D_RST          = 16'd23040;
  localparam logic [17:0] INTEGRAL_WINDOW_RST = 18'd30720;
  localparam logic [15:0] INTEGRAL_CLEAR_RST  = 16'd102;
  localparam logic [15:0] STALL_BAND_RST      = 16'd5;
  localparam logic [17:0] SETTLE_BAND_RST     = 18'd2048;

  localparam logic [2:0] SETTLED_MAX = 3'd7;
  localparam logic [5:0] STALLED_MAX = 6'd63;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [17:0] integral_window;
    logic [15:0] integral_clear_band;
    logic [15:0] stall_band;
    logic [17:0] settle_band;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [18:0]        target_heading;
    logic [18:0]        heading_now;
    logic signed [31:0] rotation_now;
    logic signed [31:0] rotation_after;
  } item_t;

  typedef struct packed {
    logic signed [31:0] target_rotation;
    logic signed [31:0] last_error;
    logic signed [39:0] integral_sum;
    logic [2:0]         settled_ticks;
    logic [5:0]         stalled_ticks;
    logic               done_flag;
  } state_t;

  typedef struct packed {
    logic signed [14:0] left_drive;
    logic signed [14:0] right_drive;
    logic               finished;
  } result_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

endpackage

@@ sv/hpid_regs.sv @@
module hpid_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output hpid_pkg::cfg_t     cfg
);

  hpid_pkg::cfg_t   cfg_r;
  hpid_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p              <= hpid_pkg::GAIN_P_RST;
      cfg_r.gain_i              <= hpid_pkg::GAIN_I_RST;
      cfg_r.gain_d              <= hpid_pkg::GAIN_D_RST;
      cfg_r.integral_window     <= hpid_pkg::INTEGRAL_WINDOW_RST;
      cfg_r.integral_clear_band <= hpid_pkg::INTEGRAL_CLEAR_RST;
      cfg_r.stall_band          <= hpid_pkg::STALL_BAND_RST;
      cfg_r.settle_band         <= hpid_pkg::SETTLE_BAND_RST;
    end else if (wr_en) begin
      case (idx)
        hpid_pkg::REG_GAIN_P:          cfg_r.gain_p              <= cfg_pwdata[15:0];
        hpid_pkg::REG_GAIN_I:          cfg_r.gain_i              <= cfg_pwdata[15:0];
        hpid_pkg::REG_GAIN_D:          cfg_r.gain_d              <= cfg_pwdata[15:0];
        hpid_pkg::REG_INTEGRAL_WINDOW: cfg_r.integral_window     <= cfg_pwdata[17:0];
        hpid_pkg::REG_INTEGRAL_CLEAR:  cfg_r.integral_clear_band <= cfg_pwdata[15:0];
        hpid_pkg::REG_STALL_BAND:      cfg_r.stall_band          <= cfg_pwdata[15:0];
        hpid_pkg::REG_SETTLE_BAND:     cfg_r.settle_band         <= cfg_pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hpid_pkg::REG_GAIN_P:          cfg_prdata = {16'd0, cfg_r.gain_p};
      hpid_pkg::REG_GAIN_I:          cfg_prdata = {16'd0, cfg_r.gain_i};
      hpid_pkg::REG_GAIN_D:          cfg_prdata = {16'd0, cfg_r.gain_d};
      hpid_pkg::REG_INTEGRAL_WINDOW: cfg_prdata = {14'd0, cfg_r.integral_window};
      hpid_pkg::REG_INTEGRAL_CLEAR:  cfg_prdata = {16'd0, cfg_r.integral_clear_band};
      hpid_pkg::REG_STALL_BAND:      cfg_prdata = {16'd0, cfg_r.stall_band};
      hpid_pkg::REG_SETTLE_BAND:     cfg_prdata = {14'd0, cfg_r.settle_band};
      default:                       cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/hpid_fold.sv @@
module hpid_fold (
  input  logic [18:0]        target_heading,
  input  logic [18:0]        heading_now,
  output logic signed [18:0] angle
);

  localparam logic signed [19:0] FULL = 20'(hpid_pkg::FULL_TURN);
  localparam logic signed [19:0] HALF = 20'(hpid_pkg::HALF_TURN);

  logic signed [19:0] diff;
  logic signed [19:0] rem;
  logic signed [19:0] folded;

  assign diff = $signed({1'b0, target_heading}) - $signed({1'b0, heading_now});

  // |diff| stays below two full turns, so one correction gives the truncated remainder
  always_comb begin
    if (diff >= FULL)
      rem = diff - FULL;
    else if (diff <= -FULL)
      rem = diff + FULL;
    else
      rem = diff;

    if (rem > HALF)
      folded = rem - FULL;
    else if (rem < -HALF)
      folded = rem + FULL;
    else
      folded = rem;
  end

  assign angle = folded[18:0];

endmodule

@@ sv/hpid_calc.sv @@
module hpid_calc #(
  parameter int SETTLE_TICKS = 5,
  parameter int STALL_TICKS  = 50
) (
  input  hpid_pkg::item_t   item,
  input  hpid_pkg::state_t  st,
  input  hpid_pkg::cfg_t    cfg,
  output hpid_pkg::state_t  st_nxt,
  output hpid_pkg::result_t res
);

  localparam logic [2:0] SETTLE_LIM = 3'(SETTLE_TICKS);
  localparam logic [5:0] STALL_LIM  = 6'(STALL_TICKS);
  localparam logic signed [39:0] INTEG_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] INTEG_MIN = {1'b1, {39{1'b0}}};
  localparam logic signed [39:0] DRV_MAX   = 40'(hpid_pkg::DRIVE_MAX);
  localparam logic signed [57:0] ROUND_HALF = 58'sd131072;

  logic signed [18:0] angle;
  logic signed [31:0] err;
  logic [31:0]        err_abs;
  logic signed [32:0] deriv;
  logic [32:0]        deriv_abs;
  logic signed [40:0] integ_sum;
  logic signed [39:0] integ_sat;
  logic signed [39:0] integ_acc;
  logic signed [39:0] integ_new;
  logic [5:0]         stalled_new;
  logic signed [31:0] rem_dist;
  logic [31:0]        dist_abs;
  logic [2:0]         settled_new;
  logic signed [48:0] prod_p;
  logic signed [56:0] prod_i;
  logic signed [49:0] prod_d;
  logic signed [57:0] acc;
  logic signed [39:0] drv_full;
  logic signed [14:0] drive;
  logic               fin;

  hpid_fold u_fold (
    .target_heading (item.target_heading),
    .heading_now    (item.heading_now),
    .angle          (angle)
  );

  assign err     = st.target_rotation - item.rotation_now;
  assign err_abs = err[31] ? (~err + 32'd1) : err;
  assign deriv   = {err[31], err} - {st.last_error[31], st.last_error};
  assign deriv_abs = deriv[32] ? (~deriv + 33'd1) : deriv;

  assign integ_sum = {st.integral_sum[39], st.integral_sum} + {{9{err[31]}}, err};

  always_comb begin
    if (integ_sum[40] != integ_sum[39])
      integ_sat = integ_sum[40] ? INTEG_MIN : INTEG_MAX;
    else
      integ_sat = integ_sum[39:0];
  end

  assign integ_acc = (err_abs < {14'd0, cfg.integral_window}) ? integ_sat : st.integral_sum;
  assign integ_new = (err_abs < {16'd0, cfg.integral_clear_band}) ? 40'sd0 : integ_acc;

  always_comb begin
    if (deriv_abs < {17'd0, cfg.stall_band})
      stalled_new = (st.stalled_ticks == hpid_pkg::STALLED_MAX) ? st.stalled_ticks
                                                               : st.stalled_ticks + 6'd1;
    else
      stalled_new = 6'd0;
  end

  assign rem_dist = st.target_rotation - item.rotation_after;
  assign dist_abs = rem_dist[31] ? (~rem_dist + 32'd1) : rem_dist;

  always_comb begin
    if (dist_abs < {14'd0, cfg.settle_band})
      settled_new = (st.settled_ticks == hpid_pkg::SETTLED_MAX) ? st.settled_ticks
                                                               : st.settled_ticks + 3'd1;
    else
      settled_new = 3'd0;
  end

  // products are Q18 millivolts
  assign prod_p = $signed({1'b0, cfg.gain_p}) * err;
  assign prod_i = $signed({1'b0, cfg.gain_i}) * integ_new;
  assign prod_d = $signed({1'b0, cfg.gain_d}) * deriv;

  assign acc      = 58'(prod_p) + 58'(prod_i) + 58'(prod_d) + ROUND_HALF;
  assign drv_full = acc[57:18];

  always_comb begin
    if (drv_full > DRV_MAX)
      drive = DRV_MAX[14:0];
    else if (drv_full < -DRV_MAX)
      drive = 15'(-DRV_MAX);
    else
      drive = drv_full[14:0];
  end

  assign fin = (settled_new >= SETTLE_LIM) || (stalled_new >= STALL_LIM);

  always_comb begin
    st_nxt          = st;
    res.left_drive  = 15'sd0;
    res.finished    = 1'b0;
    if (item.cmd == hpid_pkg::CMD_START) begin
      st_nxt.target_rotation = item.rotation_now + {{13{angle[18]}}, angle};
      st_nxt.last_error      = {{13{angle[18]}}, angle};
      st_nxt.integral_sum    = 40'sd0;
      st_nxt.settled_ticks   = 3'd0;
      st_nxt.stalled_ticks   = 6'd0;
      st_nxt.done_flag       = 1'b0;
    end else if (st.done_flag) begin
      // idle tick leaves the state alone
      res.finished = 1'b1;
    end else begin
      st_nxt.last_error    = err;
      st_nxt.integral_sum  = integ_new;
      st_nxt.settled_ticks = settled_new;
      st_nxt.stalled_ticks = stalled_new;
      st_nxt.done_flag     = fin;
      res.finished         = fin;
      res.left_drive       = fin ? 15'sd0 : drive;
    end
    res.right_drive = -res.left_drive;
  end

endmodule

@@ sv/heading_pid_turn_controller.sv @@
// a word accepted into the input register moves into the output register once
//   that register is free or being drained
// throughput: one word per cycle while out_tready is high; the update
//   runs in one pass between both registers, three gain multiplies in parallel
// reset (rst_n low, synchronous): gains and bands take their defaults, the
//   controller is idle (done) and both stages are empty
module heading_pid_turn_controller #(
  parameter int SETTLE_TICKS = 5,
  parameter int STALL_TICKS  = 50
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // target_heading[18:0], heading_now[37:19], rotation_now[69:38],
  // rotation_after[101:70], zero pad
  input  logic [103:0] in_tdata,
  // cmd[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_drive[14:0], right_drive[29:15], zero pad
  output logic [31:0]  out_tdata,
  // finished[0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  hpid_pkg::cfg_t    cfg;
  hpid_pkg::item_t   in_r;
  hpid_pkg::state_t  st_r;
  hpid_pkg::state_t  st_calc;
  hpid_pkg::state_t  st_nxt;
  hpid_pkg::result_t res;
  hpid_pkg::result_t out_r;
  logic              in_vld_r;
  logic              in_vld_nxt;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic              advance;
  logic              in_take;

  hpid_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hpid_calc #(
    .SETTLE_TICKS (SETTLE_TICKS),
    .STALL_TICKS  (STALL_TICKS)
  ) u_calc (
    .item   (in_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_calc),
    .res    (res)
  );

  // the held word moves on whenever the output register is free or being drained
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign in_take   = in_tvalid && in_tready;

  assign in_vld_nxt  = in_take || (in_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && !out_tready);
  assign st_nxt      = advance ? st_calc : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r                 <= 1'b0;
      out_vld_r                <= 1'b0;
      st_r.target_rotation     <= 32'sd0;
      st_r.last_error          <= 32'sd0;
      st_r.integral_sum        <= 40'sd0;
      st_r.settled_ticks       <= 3'd0;
      st_r.stalled_ticks       <= 6'd0;
      st_r.done_flag           <= 1'b1;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      st_r      <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.cmd            <= in_tuser[0];
      in_r.target_heading <= in_tdata[18:0];
      in_r.heading_now    <= in_tdata[37:19];
      in_r.rotation_now   <= in_tdata[69:38];
      in_r.rotation_after <= in_tdata[101:70];
    end
    if (advance)
      out_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_r.right_drive, out_r.left_drive};
  assign out_tuser  = out_r.finished;

endmodule

@@ sv/hpid_checker.sv @@
module hpid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  logic [14:0]        neg_sum;
  logic signed [14:0] left_s;

  assign neg_sum = out_tdata[14:0] + out_tdata[29:15];
  assign left_s  = out_tdata[14:0];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_finish_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0)
    else $error("finished word carries drive");

  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> neg_sum == 15'd0 && out_tdata[31:30] == 2'b00)
    else $error("right drive is not the negation of left");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> left_s <= 15'sd12000 && left_s >= -15'sd12000)
    else $error("drive outside saturation limits");

endmodule

bind heading_pid_turn_controller hpid_checker u_hpid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
